/* design/seq_numbered_frame_reassembler_defines.svh */
// ---------------------------------------------------------------------------
// seq_numbered_frame_reassembler_defines.svh
// Assertion macros for the frame reassembler.
// ---------------------------------------------------------------------------
`ifndef SEQ_NUMBERED_FRAME_REASSEMBLER_DEFINES_SVH
`define SEQ_NUMBERED_FRAME_REASSEMBLER_DEFINES_SVH

`ifndef SYNTHESIS
`define SNFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("snfr assertion failed");
`define SNFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snfr assertion failed");
`else
`define SNFR_ASSERT(label, clk, rst_n, prop)
`define SNFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/snfr_pkg.sv */
// ---------------------------------------------------------------------------
// snfr_pkg
// Types and constants for the sequence-numbered frame reassembler.
// ---------------------------------------------------------------------------
package snfr_pkg;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int FRAME_LEN_W  = 13;
    localparam int OFFSET_W     = 12;
    localparam int LOST_W       = 32;

    typedef enum logic [0:0] {
        REG_FRAME_LENGTH = 1'b0
    } reg_index_t;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RESET = 13'd64;

    typedef struct packed {
        logic                 store_valid;
        logic [7:0]           data_byte;
        logic [OFFSET_W-1:0]  byte_offset;
        logic                 frame_done;
        logic                 frame_abort;
        logic [LOST_W-1:0]    lost_frame_count;
    } result_t;

endpackage

/* design/seq_numbered_frame_reassembler.sv */
// ---------------------------------------------------------------------------
// seq_numbered_frame_reassembler
// Rebuilds frames from index-numbered packets, one byte word per cycle.
// ---------------------------------------------------------------------------
// Takes one packet byte per cycle and returns one registered result word per
// byte. All per-byte state (expected index, stored count, skip flag, lost
// counter) is updated at input accept, so the block sustains one word per
// clock. An output register and a one-entry skid stage sit on the result
// side; in_ready drops only while the skid stage is full. frame_length lies
// at byte address 0 (APB); 0 acts as 1 and values above MAX_FRAME_BYTES act
// as MAX_FRAME_BYTES. Write it only while idle.
module seq_numbered_frame_reassembler #(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [snfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [snfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [snfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      byte_value,
    input  logic                            packet_start,
    input  logic                            packet_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            store_valid,
    output logic [7:0]                      data_byte,
    output logic [snfr_pkg::OFFSET_W-1:0]   byte_offset,
    output logic                            frame_done,
    output logic                            frame_abort,
    output logic [snfr_pkg::LOST_W-1:0]     lost_frame_count
);
    import snfr_pkg::*;

`include "seq_numbered_frame_reassembler_defines.svh"

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [FRAME_LEN_W-1:0] frame_length_reg;
    logic [7:0]             expected_index_reg;
    logic [LEN_W-1:0]       stored_count_reg;
    logic                   skip_packet_reg;
    logic                   packet_has_data_reg;
    logic [LOST_W-1:0]      lost_count_reg;

    logic [7:0]             expected_index_next;
    logic [LEN_W-1:0]       stored_count_next;
    logic                   skip_packet_next;
    logic                   packet_has_data_next;
    logic [LOST_W-1:0]      lost_count_next;

    result_t                out_reg;
    result_t                skid_reg;
    logic                   out_valid_reg;
    logic                   skid_full_reg;
    result_t                res;

    logic                   cfg_write;
    logic                   in_acc;
    logic [31:0]            len_ext;
    logic [LEN_W-1:0]       eff_len;
    logic [31:0]            offs_ext;
    logic [1:0]             lost_inc;

    // configuration port
    assign pready    = 1'b1;
    assign prdata    = CFG_DATA_W'(frame_length_reg);
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == REG_FRAME_LENGTH);

    always_comb
    begin
        len_ext = 32'(frame_length_reg);
        if (len_ext == 32'd0)
        begin
            len_ext = 32'd1;
        end
        else if (len_ext > 32'(MAX_FRAME_BYTES))
        begin
            len_ext = 32'(MAX_FRAME_BYTES);
        end
        eff_len = len_ext[LEN_W-1:0];
    end

    assign in_ready = !skid_full_reg;
    assign in_acc   = in_valid && in_ready;

    // per-byte state update
    always_comb
    begin
        expected_index_next  = expected_index_reg;
        stored_count_next    = stored_count_reg;
        skip_packet_next     = skip_packet_reg;
        packet_has_data_next = packet_has_data_reg;
        lost_inc             = 2'd0;
        res                  = '0;
        offs_ext             = 32'(stored_count_reg);

        if (packet_start)
        begin
            skip_packet_next     = 1'b0;
            packet_has_data_next = 1'b0;
            if (byte_value != expected_index_reg)
            begin
                if (stored_count_reg != '0)
                begin
                    lost_inc        = lost_inc + 2'd1;
                    res.frame_abort = 1'b1;
                end
                stored_count_next   = '0;
                expected_index_next = 8'd0;
                if (byte_value != 8'd0)
                begin
                    lost_inc         = lost_inc + 2'd1;
                    skip_packet_next = 1'b1;
                end
            end
        end
        else if (!skip_packet_reg)
        begin
            packet_has_data_next = 1'b1;
            if (stored_count_reg < eff_len)
            begin
                res.store_valid   = 1'b1;
                res.data_byte     = byte_value;
                res.byte_offset   = offs_ext[OFFSET_W-1:0];
                stored_count_next = stored_count_reg + LEN_W'(1);
            end
        end

        if (packet_end)
        begin
            if (!skip_packet_next)
            begin
                if (packet_has_data_next)
                begin
                    expected_index_next = expected_index_next + 8'd1;
                end
                if (stored_count_next == eff_len)
                begin
                    res.frame_done      = 1'b1;
                    stored_count_next   = '0;
                    expected_index_next = 8'd0;
                end
            end
            skip_packet_next     = 1'b0;
            packet_has_data_next = 1'b0;
        end

        lost_count_next      = lost_count_reg + LOST_W'(lost_inc);
        res.lost_frame_count = lost_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg    <= FRAME_LENGTH_RESET;
            expected_index_reg  <= 8'd0;
            stored_count_reg    <= '0;
            skip_packet_reg     <= 1'b0;
            packet_has_data_reg <= 1'b0;
            lost_count_reg      <= '0;
            out_valid_reg       <= 1'b0;
            skid_full_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                frame_length_reg <= pwdata[FRAME_LEN_W-1:0];
            end
            if (in_acc)
            begin
                expected_index_reg  <= expected_index_next;
                stored_count_reg    <= stored_count_next;
                skip_packet_reg     <= skip_packet_next;
                packet_has_data_reg <= packet_has_data_next;
                lost_count_reg      <= lost_count_next;
            end
            if (out_ready || !out_valid_reg)
            begin
                if (skid_full_reg)
                begin
                    out_valid_reg <= 1'b1;
                    skid_full_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_acc;
                end
            end
            else if (in_acc)
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_full_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= res;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign store_valid      = out_reg.store_valid;
    assign data_byte        = out_reg.data_byte;
    assign byte_offset      = out_reg.byte_offset;
    assign frame_done       = out_reg.frame_done;
    assign frame_abort      = out_reg.frame_abort;
    assign lost_frame_count = out_reg.lost_frame_count;

    `SNFR_ASSERT(a_skid_implies_out, clk, rst_n, !skid_full_reg || out_valid_reg)
    `SNFR_ASSERT(a_abort_no_store, clk, rst_n, !(out_valid_reg && out_reg.frame_abort && out_reg.store_valid))
    `SNFR_ASSERT_NEXT(a_lost_hold, clk, rst_n, !in_acc, lost_count_reg == $past(lost_count_reg))

endmodule

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sequence-numbered frame reassembler.
// ---------------------------------------------------------------------------
// Feeds packet byte words through the valid/ready input and checks every
// result word against an in-bench predictor of the reassembly rules. The
// frame length is set over APB between traffic phases, including the
// clamped extremes. Short directed sequences are followed by mostly
// well-formed frames with random payload. The rest of the traffic is wrong
// indices, unterminated packets and stray bytes. One long phase walks the
// packet index through its 8-bit wrap. Both sides insert random gaps.
// ---------------------------------------------------------------------------
module testbench;

    import snfr_pkg::*;

    localparam int MAX_FRAME     = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_start;
        logic       is_end;
    } pkt_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            byte_value = '0;
    logic                  packet_start = 1'b0;
    logic                  packet_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  store_valid;
    logic [7:0]            data_byte;
    logic [OFFSET_W-1:0]   byte_offset;
    logic                  frame_done;
    logic                  frame_abort;
    logic [LOST_W-1:0]     lost_frame_count;

    seq_numbered_frame_reassembler #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .byte_value(byte_value),
        .packet_start(packet_start),
        .packet_end(packet_end),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .store_valid(store_valid),
        .data_byte(data_byte),
        .byte_offset(byte_offset),
        .frame_done(frame_done),
        .frame_abort(frame_abort),
        .lost_frame_count(lost_frame_count)
    );

    // predictor state
    logic [FRAME_LEN_W-1:0] cfg_frame_len = FRAME_LENGTH_RESET;
    logic [7:0]             next_index = '0;
    logic [FRAME_LEN_W-1:0] held_bytes = '0;
    logic                   skipping = 1'b0;
    logic                   pkt_has_payload = 1'b0;
    logic [LOST_W-1:0]      lost_total = '0;

    pkt_word_t pending_words[$];
    result_t   reassembly_out_q[$];
    pkt_word_t cur_word;

    int  error_count = 0;
    int  words_accepted = 0;
    int  results_checked = 0;
    int  frames_completed = 0;
    int  frames_aborted = 0;
    int  length_settings = 1;
    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  tx_no_idle = 1'b0;
    bit  rx_no_idle = 1'b0;
    bit  drain_wait = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int effective_len();
        if (cfg_frame_len == 0)
            return 1;
        if (cfg_frame_len > MAX_FRAME)
            return MAX_FRAME;
        return int'(cfg_frame_len);
    endfunction

    function automatic int draw_wait(bit no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    task automatic reassemble_word(input pkt_word_t w);
        result_t r;
        int      len;
        len = effective_len();
        r = '0;
        if (w.is_start)
        begin
            skipping = 1'b0;
            pkt_has_payload = 1'b0;
            if (w.value != next_index)
            begin
                if (held_bytes != 0)
                begin
                    lost_total++;
                    r.frame_abort = 1'b1;
                    frames_aborted++;
                end
                held_bytes = '0;
                next_index = '0;
                if (w.value != 0)
                begin
                    lost_total++;
                    skipping = 1'b1;
                end
            end
        end
        else if (!skipping)
        begin
            pkt_has_payload = 1'b1;
            if (held_bytes < len)
            begin
                r.store_valid = 1'b1;
                r.data_byte = w.value;
                r.byte_offset = held_bytes[OFFSET_W-1:0];
                held_bytes++;
            end
        end
        if (w.is_end)
        begin
            if (!skipping)
            begin
                if (pkt_has_payload)
                    next_index++;
                if (held_bytes == len)
                begin
                    r.frame_done = 1'b1;
                    frames_completed++;
                    held_bytes = '0;
                    next_index = '0;
                end
            end
            skipping = 1'b0;
            pkt_has_payload = 1'b0;
        end
        r.lost_frame_count = lost_total;
        reassembly_out_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                reassemble_word(cur_word);
                words_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap--;
                end
                else if (drain_wait && reassembly_out_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    byte_value <= cur_word.value;
                    packet_start <= cur_word.is_start;
                    packet_end <= cur_word.is_end;
                    if ($urandom_range(0, 39) == 0)
                        tx_no_idle = !tx_no_idle;
                    tx_gap = draw_wait(tx_no_idle);
                    drain_wait = ($urandom_range(0, 59) == 0) || (words_accepted == 150);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reassembly_out_q.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, actual offset %0h data %0h",
                             $time, byte_offset, data_byte);
                    error_count++;
                end
                else
                begin
                    want = reassembly_out_q.pop_front();
                    check_field("store_valid", 32'(store_valid), 32'(want.store_valid));
                    check_field("data_byte", 32'(data_byte), 32'(want.data_byte));
                    check_field("byte_offset", 32'(byte_offset), 32'(want.byte_offset));
                    check_field("frame_done", 32'(frame_done), 32'(want.frame_done));
                    check_field("frame_abort", 32'(frame_abort), 32'(want.frame_abort));
                    check_field("lost_frame_count", 32'(lost_frame_count),
                                32'(want.lost_frame_count));
                    results_checked++;
                end
                if ($urandom_range(0, 39) == 0)
                    rx_no_idle = !rx_no_idle;
                rx_stall = draw_wait(rx_no_idle);
            end
            if (rx_stall > 0)
            begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     reassembly_out_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_word(input logic [7:0] value, input logic s, input logic e);
        pkt_word_t w;
        w.value = value;
        w.is_start = s;
        w.is_end = e;
        pending_words.push_back(w);
    endtask

    task automatic add_packet(input logic [7:0] idx, input int npay, input bit close);
        add_word(idx, 1'b1, close && npay == 0);
        for (int i = 0; i < npay; i++)
            add_word(8'($urandom_range(0, 255)), 1'b0, close && i == npay - 1);
    endtask

    task automatic add_random_traffic(input int n);
        int target;
        int len;
        int idx;
        int remaining;
        int take;
        int pick;
        target = pending_words.size() + n;
        len = effective_len();
        while (pending_words.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                remaining = len;
                idx = 0;
                while (remaining > 0 && pending_words.size() < target)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_packet(8'(idx), 0, 1'b1);
                    take = $urandom_range(1, remaining < 5 ? remaining : 5);
                    if (take == remaining && $urandom_range(0, 5) == 0)
                        take += $urandom_range(1, 3);
                    add_packet(8'(idx), take, 1'b1);
                    idx++;
                    remaining -= take;
                end
            end
            else if (pick < 78)
                add_packet(8'($urandom_range(0, 255)), $urandom_range(0, 4), 1'b1);
            else if (pick < 86)
                add_packet(8'($urandom_range(0, 1)), $urandom_range(0, 3), 1'b0);
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 3))
                    add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            else
                add_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || reassembly_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_length(input logic [FRAME_LEN_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(int'(REG_FRAME_LENGTH) * 4);
        pwdata <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_frame_len = value;
        length_settings++;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // stray bytes after reset, then a mismatch that drops held bytes
        add_word(8'h00, 1'b0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b1);
        add_word(8'h01, 1'b1, 1'b0);
        add_word(8'hA5, 1'b0, 1'b0);
        add_word(8'h5A, 1'b0, 1'b1);
        add_packet(8'h07, 2, 1'b1);
        add_packet(8'hFF, 0, 1'b1);
        wait_drained();

        // empty packet, overlong packet, unterminated packet
        write_frame_length(13'd3);
        add_packet(8'h00, 2, 1'b1);
        add_packet(8'h01, 0, 1'b1);
        add_packet(8'h01, 3, 1'b1);
        add_packet(8'h00, 1, 1'b0);
        add_packet(8'h00, 2, 1'b1);
        add_random_traffic(50);
        wait_drained();

        write_frame_length(13'd1);
        add_random_traffic(60);
        wait_drained();

        write_frame_length(13'd0);
        add_random_traffic(50);
        wait_drained();

        // long frame of one-byte packets walks the index through its wrap
        write_frame_length(13'h1FFF);
        for (int i = 0; i < 258; i++)
            add_packet(8'(i), 1, 1'b1);
        add_packet(8'h09, 2, 1'b1);
        add_random_traffic(20);
        wait_drained();

        write_frame_length(13'd4096);
        add_random_traffic(40);
        wait_drained();

        write_frame_length(13'd2);
        add_random_traffic(60);
        wait_drained();

        write_frame_length(13'($urandom_range(4, 24)));
        add_random_traffic(40);
        wait_drained();

        $display("Sent %0d byte words over %0d frame length settings, %0d results checked.",
                 words_accepted, length_settings, results_checked);
        $display("Frames completed: %0d, aborted: %0d, lost-frame count: %0d.",
                 frames_completed, frames_aborted, lost_total);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/snfr_pkg.sv
design/seq_numbered_frame_reassembler.sv
sim/testbench.sv
